>>> rtl/ps2md_pkg.sv
`default_nettype none

package ps2md_pkg;

  // Header byte bit positions
  localparam int HdrLeftBit   = 0;
  localparam int HdrRightBit  = 1;
  localparam int HdrMiddleBit = 2;
  localparam int HdrOneBit    = 3;
  localparam int HdrXSignBit  = 4;
  localparam int HdrYSignBit  = 5;
  localparam int HdrXOvfBit   = 6;
  localparam int HdrYOvfBit   = 7;

  // Field widths
  localparam int ByteW  = 8;
  localparam int SensW  = 10;
  localparam int MoveW  = 10;   // nine-bit movement, negated Y needs +256
  localparam int ProdW  = 20;   // signed movement times sensitivity
  localparam int MagW   = 18;   // |product| <= 256 * 1023
  localparam int DeltaW = 13;

  // Divide by 100 as multiply by ceil(2^25 / 100), exact for MagW-bit inputs
  localparam int RecipShift = 25;
  localparam int RecipW     = 19;
  localparam logic [RecipW-1:0] RecipMul = RecipW'((2 ** RecipShift + 99) / 100);
  localparam int QuotW      = DeltaW - 1;

  localparam logic [SensW-1:0] SensReset = SensW'(100);

  // Assembled packet handed from the byte assembler to the scaler
  typedef struct packed {
    logic             pvalid;
    logic [MoveW-1:0] dx;
    logic [MoveW-1:0] dy;
    logic             left;
    logic             right;
    logic             middle;
  } pkt_t;

endpackage

`default_nettype wire

>>> rtl/ps2md_asm.sv
`default_nettype none

module ps2md_asm (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ps2md_pkg::ByteW-1:0]   in_rx_byte,
  output logic                               pkt_valid,
  output ps2md_pkg::pkt_t                    pkt,
  input  wire logic                          dn_ready
);
  import ps2md_pkg::*;

  localparam logic [1:0] POS_HDR = 2'd0;
  localparam logic [1:0] POS_X   = 2'd1;
  localparam logic [1:0] POS_Y   = 2'd2;

  logic [1:0]       pos_r, pos_nxt;
  logic [ByteW-1:0] hdr_r, hdr_nxt;
  logic [ByteW-1:0] xb_r, xb_nxt;
  logic             pkt_v_r, pkt_v_nxt;
  pkt_t             pkt_r, pkt_nxt;
  logic             acc;
  logic             emit;
  logic             ovf;
  logic [MoveW-1:0] y_raw;

  // A new word may enter while the packet slot is free or draining
  assign in_stall = pkt_v_r && !dn_ready;
  assign acc      = in_valid && !in_stall;

  // Byte position sequencer
  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    xb_nxt  = xb_r;
    emit    = 1'b0;
    if (acc) begin
      unique case (pos_r)
        POS_HDR: begin
          if (in_rx_byte[HdrOneBit]) begin
            hdr_nxt = in_rx_byte;
            pos_nxt = POS_X;
          end
        end
        POS_X: begin
          xb_nxt  = in_rx_byte;
          pos_nxt = POS_Y;
        end
        POS_Y: begin
          pos_nxt = POS_HDR;
          emit    = 1'b1;
        end
        default: begin
          pos_nxt = POS_HDR;
        end
      endcase
    end
  end

  // Packet fields; an overflowed packet carries all zeros
  assign ovf   = hdr_r[HdrXOvfBit] || hdr_r[HdrYOvfBit];
  assign y_raw = {{(MoveW-ByteW){hdr_r[HdrYSignBit]}}, in_rx_byte};

  always_comb begin
    pkt_nxt = '0;
    if (!ovf) begin
      pkt_nxt.pvalid = 1'b1;
      pkt_nxt.dx     = {{(MoveW-ByteW){hdr_r[HdrXSignBit]}}, xb_r};
      pkt_nxt.dy     = MoveW'(0) - y_raw;
      pkt_nxt.left   = hdr_r[HdrLeftBit];
      pkt_nxt.right  = hdr_r[HdrRightBit];
      pkt_nxt.middle = hdr_r[HdrMiddleBit];
    end
  end

  assign pkt_v_nxt = emit || (pkt_v_r && !dn_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HDR;
      hdr_r   <= '0;
      xb_r    <= '0;
      pkt_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      xb_r    <= xb_nxt;
      pkt_v_r <= pkt_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_valid = pkt_v_r;
  assign pkt       = pkt_r;

  // Third byte of a packet always fills the packet slot
  a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (pos_r == POS_Y) |=> pkt_v_r)
    else $error("third byte did not produce a packet");

  // A held packet is not overwritten
  a_pkt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_v_r && !dn_ready |=> pkt_v_r && $stable(pkt_r))
    else $error("held packet changed");

  // An accepted X byte always advances the sequencer to the Y position
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (pos_r == POS_X) |=> (pos_r == POS_Y))
    else $error("X byte did not advance to Y position");

endmodule

`default_nettype wire

>>> rtl/ps2md_scale.sv
`default_nettype none

module ps2md_scale (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                pkt_valid,
  input  wire ps2md_pkg::pkt_t                     pkt,
  output logic                                     up_ready,
  input  wire logic [ps2md_pkg::SensW-1:0]         sens,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_packet_valid,
  output logic signed [ps2md_pkg::DeltaW-1:0]      out_delta_x,
  output logic signed [ps2md_pkg::DeltaW-1:0]      out_delta_y,
  output logic                                     out_left_button,
  output logic                                     out_right_button,
  output logic                                     out_middle_button
);
  import ps2md_pkg::*;

  // Signed product divided by 100, truncating toward zero
  function automatic logic [DeltaW-1:0] div100(input logic [ProdW-1:0] p);
    logic                     neg;
    logic [ProdW-1:0]         abs_p;
    logic [MagW+RecipW-1:0]   qm;
    logic [QuotW-1:0]         q;
    neg   = p[ProdW-1];
    abs_p = neg ? (ProdW'(0) - p) : p;
    qm    = (MagW+RecipW)'(abs_p[MagW-1:0]) * (MagW+RecipW)'(RecipMul);
    q     = qm[RecipShift +: QuotW];
    return neg ? (DeltaW'(0) - {1'b0, q}) : {1'b0, q};
  endfunction

  logic                    m_v_r, m_v_nxt;
  logic [ProdW-1:0]        px_r, py_r;
  logic                    m_pv_r, m_l_r, m_r_r, m_m_r;
  logic                    m_ready;
  logic                    m_load;
  logic signed [ProdW-1:0] sx, sy, ss;

  logic                    o_v_r, o_v_nxt;
  logic                    o_pv_r, o_l_r, o_r_r, o_m_r;
  logic [DeltaW-1:0]       ox_r, oy_r;
  logic                    o_ready;
  logic                    o_load;

  // Ready chain back from the output register
  assign o_ready  = !o_v_r || !out_stall;
  assign m_ready  = !m_v_r || o_ready;
  assign up_ready = m_ready;
  assign m_load   = pkt_valid && m_ready;
  assign o_load   = m_v_r && o_ready;

  // Multiply stage operands: movement sign extended, sensitivity zero extended, to product width
  assign sx = {{(ProdW-MoveW){pkt.dx[MoveW-1]}}, pkt.dx};
  assign sy = {{(ProdW-MoveW){pkt.dy[MoveW-1]}}, pkt.dy};
  assign ss = {{(ProdW-SensW){1'b0}}, sens};

  assign m_v_nxt = m_load || (m_v_r && !o_ready);
  assign o_v_nxt = o_load || (o_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      m_v_r <= m_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (m_load) begin
      px_r   <= sx * ss;
      py_r   <= sy * ss;
      m_pv_r <= pkt.pvalid;
      m_l_r  <= pkt.left;
      m_r_r  <= pkt.right;
      m_m_r  <= pkt.middle;
    end
  end

  // Reciprocal divide stage into the output register
  always_ff @(posedge clk) begin
    if (o_load) begin
      ox_r   <= div100(px_r);
      oy_r   <= div100(py_r);
      o_pv_r <= m_pv_r;
      o_l_r  <= m_l_r;
      o_r_r  <= m_r_r;
      o_m_r  <= m_m_r;
    end
  end

  assign out_valid         = o_v_r;
  assign out_packet_valid  = o_pv_r;
  assign out_delta_x       = $signed(ox_r);
  assign out_delta_y       = $signed(oy_r);
  assign out_left_button   = o_l_r;
  assign out_right_button  = o_r_r;
  assign out_middle_button = o_m_r;

  // An overflowed packet carries no movement and no buttons
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !o_pv_r |-> (ox_r == '0) && (oy_r == '0) && !o_l_r && !o_r_r && !o_m_r)
    else $error("overflowed packet has nonzero fields");

  // Output drains when taken and nothing follows from the multiply stage
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !out_stall && !m_v_r |=> !o_v_r)
    else $error("output word repeated");

  // A multiply word is never lost while the output is stalled
  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_v_r && o_v_r && out_stall |=> m_v_r && $stable(px_r) && $stable(py_r))
    else $error("multiply stage word lost");

endmodule

`default_nettype wire

>>> rtl/ps2_mouse_packet_decoder.sv
`default_nettype none

// PS/2 mouse packet decoder.
// Input channel: one received mouse byte per word on in_rx_byte, handshake
// in_valid / in_stall. Bytes are assembled into header, X and Y; a header
// word without its always-one bit is dropped.
// Output channel: one word per complete packet (buttons, scaled X, negated
// and scaled Y, packet_valid), handshake out_valid / out_stall.
// Config: cfg_wr_en writes cfg_wr_data into the sensitivity register
// (percent, reset value 100); write it only while no packet is in flight.
// Throughput: one byte per cycle while the receiver does not stall. The
// result word passes from the packet register, which loads on the edge that
// accepts the third byte, through the multiply register to the divide-by-100
// output register.
// Reset (synchronous, active low) empties all stages, returns the byte
// position to the header and sets sensitivity to 100.
// When the receiver stalls, the output word holds; the two inner stages fill
// behind it and in_stall rises once the packet register is also held.

module ps2_mouse_packet_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ps2md_pkg::ByteW-1:0]         in_rx_byte,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_packet_valid,
  output logic signed [ps2md_pkg::DeltaW-1:0]      out_delta_x,
  output logic signed [ps2md_pkg::DeltaW-1:0]      out_delta_y,
  output logic                                     out_left_button,
  output logic                                     out_right_button,
  output logic                                     out_middle_button,
  input  wire logic                                cfg_wr_en,
  input  wire logic [ps2md_pkg::SensW-1:0]         cfg_wr_data
);
  import ps2md_pkg::*;

  logic [SensW-1:0] sens_r;
  logic             pkt_valid;
  pkt_t             pkt;
  logic             dn_ready;

  // Sensitivity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= SensReset;
    end else if (cfg_wr_en) begin
      sens_r <= cfg_wr_data;
    end
  end

  ps2md_asm u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .pkt_valid  (pkt_valid),
    .pkt        (pkt),
    .dn_ready   (dn_ready)
  );

  ps2md_scale u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .pkt_valid         (pkt_valid),
    .pkt               (pkt),
    .up_ready          (dn_ready),
    .sens              (sens_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_valid  (out_packet_valid),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_left_button   (out_left_button),
    .out_right_button  (out_right_button),
    .out_middle_button (out_middle_button)
  );

endmodule

`default_nettype wire

>>> dv/ps2md_packet_checker.sv
`timescale 1ns / 1ps

module ps2md_packet_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_stall,
  input  wire logic [ps2md_pkg::ByteW-1:0]       in_rx_byte,
  input  wire logic                              out_valid,
  input  wire logic                              out_stall,
  input  wire logic                              out_packet_valid,
  input  wire logic signed [ps2md_pkg::DeltaW-1:0] out_delta_x,
  input  wire logic signed [ps2md_pkg::DeltaW-1:0] out_delta_y,
  input  wire logic                              out_left_button,
  input  wire logic                              out_right_button,
  input  wire logic                              out_middle_button,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ps2md_pkg::SensW-1:0]       cfg_wr_data,
  output int                                     mismatch_count,
  output int                                     packets_checked,
  output int                                     moves_pending
);
  import ps2md_pkg::*;

  localparam int NineBitSpan = 256;
  localparam int PercentBase = 100;

  typedef enum logic [1:0] {
    POS_HEADER,
    POS_X,
    POS_Y
  } byte_pos_e;

  typedef struct {
    logic                     pvalid;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     left;
    logic                     right;
    logic                     middle;
  } mouse_move_t;

  // Shadow of the decoder state
  byte_pos_e         byte_pos;
  logic [ByteW-1:0]  header_byte;
  logic [ByteW-1:0]  x_byte;
  logic [SensW-1:0]  sensitivity;
  mouse_move_t       expected_moves [$];

  // Decode one complete packet into the move word it should produce
  function automatic mouse_move_t decode_move(logic [ByteW-1:0] hdr, logic [ByteW-1:0] xb,
                                              logic [ByteW-1:0] yb, logic [SensW-1:0] sens);
    mouse_move_t m;
    int          x_mov;
    int          y_mov;
    m = '{pvalid: 1'b0, dx: '0, dy: '0, left: 1'b0, right: 1'b0, middle: 1'b0};
    if (hdr[HdrXOvfBit] || hdr[HdrYOvfBit]) return m;
    // nine-bit two's complement, sign from the header
    x_mov = int'(xb);
    if (hdr[HdrXSignBit]) x_mov -= NineBitSpan;
    y_mov = int'(yb);
    if (hdr[HdrYSignBit]) y_mov -= NineBitSpan;
    y_mov = -y_mov;
    // integer division truncates toward zero
    m.pvalid = 1'b1;
    m.dx     = DeltaW'((x_mov * int'(sens)) / PercentBase);
    m.dy     = DeltaW'((y_mov * int'(sens)) / PercentBase);
    m.left   = hdr[HdrLeftBit];
    m.right  = hdr[HdrRightBit];
    m.middle = hdr[HdrMiddleBit];
    return m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("packet %0d %s got %0d want %0d", packets_checked, name, got,
                                want));
  endtask

  always @(posedge clk) begin : track
    mouse_move_t want;
    if (!rst_n) begin
      byte_pos        = POS_HEADER;
      header_byte     = '0;
      x_byte          = '0;
      sensitivity     = SensReset;
      mismatch_count  = 0;
      packets_checked = 0;
      expected_moves.delete();
    end else begin
      if (cfg_wr_en) sensitivity = cfg_wr_data;

      // compare each accepted move word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_moves.size() == 0) begin
          report_mismatch("move word with no packet outstanding");
        end else begin
          want = expected_moves.pop_front();
          check_field("packet_valid", out_packet_valid, want.pvalid);
          check_field("delta_x", out_delta_x, want.dx);
          check_field("delta_y", out_delta_y, want.dy);
          check_field("left_button", out_left_button, want.left);
          check_field("right_button", out_right_button, want.right);
          check_field("middle_button", out_middle_button, want.middle);
        end
        packets_checked++;
      end

      // byte assembly; a header word without its always-one bit is dropped
      if (in_valid && !in_stall) begin
        case (byte_pos)
          POS_HEADER: begin
            if (in_rx_byte[HdrOneBit]) begin
              header_byte = in_rx_byte;
              byte_pos    = POS_X;
            end
          end
          POS_X: begin
            x_byte   = in_rx_byte;
            byte_pos = POS_Y;
          end
          POS_Y: begin
            expected_moves.push_back(decode_move(header_byte, x_byte, in_rx_byte, sensitivity));
            byte_pos = POS_HEADER;
          end
          default: byte_pos = POS_HEADER;
        endcase
      end
    end
    moves_pending <= expected_moves.size();
  end

endmodule

>>> dv/tb_ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder;
  import ps2md_pkg::*;

  localparam int NumSettings = 9;
  localparam int WordsPerSetting = 100;
  localparam int SettleCycles = 8;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic [ByteW-1:0]         in_rx_byte = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [SensW-1:0]         cfg_wr_data = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic                     out_packet_valid;
  logic signed [DeltaW-1:0] out_delta_x;
  logic signed [DeltaW-1:0] out_delta_y;
  logic                     out_left_button;
  logic                     out_right_button;
  logic                     out_middle_button;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int mismatch_count;
  int packets_checked;
  int moves_pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ps2_mouse_packet_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_valid  (out_packet_valid),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_left_button   (out_left_button),
    .out_right_button  (out_right_button),
    .out_middle_button (out_middle_button),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  ps2md_packet_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_valid  (out_packet_valid),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_left_button   (out_left_button),
    .out_right_button  (out_right_button),
    .out_middle_button (out_middle_button),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatch_count    (mismatch_count),
    .packets_checked   (packets_checked),
    .moves_pending     (moves_pending)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Present one byte word, with random gaps, and hold it until accepted
  task automatic send_byte(logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(logic [ByteW-1:0] hdr, logic [ByteW-1:0] xb, logic [ByteW-1:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Wait until every predicted move word has come out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (moves_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_sensitivity(logic [SensW-1:0] pct);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pct;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Movement bytes biased toward the boundary values
  function automatic logic [ByteW-1:0] pick_move_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return ByteW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [SensW-1:0] sens_plan [NumSettings];
    logic [ByteW-1:0] hdr;
    int               seg;
    int               seg_words;

    sens_plan = '{10'd0, 10'd1000, 10'd1023, 10'd1, 10'd100, 10'd50, 10'd999, 10'd0, 10'd0};
    repeat (7) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct = 18;
    recv_idle_pct = 52;

    // headers missing the always-one bit are dropped
    send_byte(8'h00);
    send_byte(8'hF7);
    // zero and largest positive movement, no buttons
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h08, 8'hFF, 8'hFF);
    // sign set with zero data means -256
    send_packet(8'h38, 8'h00, 8'h00);
    // all buttons with both signs, then left and middle with no sign
    send_packet(8'h3F, 8'h01, 8'hFF);
    send_packet(8'h0D, 8'h7F, 8'h80);
    // overflow on either axis blanks the word
    send_packet(8'h4F, 8'h12, 8'h34);
    send_packet(8'hBA, 8'hFF, 8'h00);
    send_packet(8'hF8, 8'h80, 8'h80);

    for (seg = 0; seg < NumSettings; seg++) begin
      drain();
      case (seg / 3)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 52;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_sensitivity(seg >= 7 ? SensW'($urandom_range(1023)) : sens_plan[seg]);

      seg_words = 0;
      while (seg_words < WordsPerSetting) begin
        if ($urandom_range(9) == 0) begin
          // stray byte: may be dropped or may knock the framing off
          send_byte(ByteW'($urandom));
        end else begin
          hdr            = ByteW'($urandom_range(63));
          hdr[HdrOneBit] = 1'b1;
          if ($urandom_range(99) < 15) begin
            hdr[HdrXOvfBit] = 1'($urandom);
            hdr[HdrYOvfBit] = 1'($urandom);
          end
          send_packet(hdr, pick_move_byte(), pick_move_byte());
          seg_words += 3;
        end
      end
    end

    drain();
    $display("Run covered %0d accepted bytes and %0d decoded packets,", bytes_sent,
             packets_checked);
    $display("over reset scale and %0d written sensitivity settings incl. 0, 1000, 1023.",
             NumSettings);
    if (mismatch_count == 0 && moves_pending == 0) begin
      $display("ps2_mouse_packet_decoder verification clean");
    end else begin
      $display("ps2_mouse_packet_decoder verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400_000;
    $display("ps2_mouse_packet_decoder verification failed");
    $finish;
  end

endmodule
